FILE: hdl/krt_pkg.sv
// Package for the keyed row table: row type, cell control type, codes and
// the row-building helpers. Used by krt_cell and keyed_row_table_compacting.
`default_nettype none

package krt_pkg;

  // Default table depth (rows held by the cell chain)
  localparam int unsigned TableDepthDef = 16;

  localparam int unsigned IdWidth    = 16;
  localparam int unsigned KindWidth  = 2;
  localparam int unsigned ValueWidth = 56;
  localparam int unsigned IntWidth   = 32;

  // Action codes
  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_DEL  = 2'd1;
  localparam logic [1:0] ACT_DUMP = 2'd2;

  // Value kinds
  localparam logic [KindWidth-1:0] KIND_INT = 2'd0;
  localparam logic [KindWidth-1:0] KIND_TXT = 2'd1;
  localparam logic [KindWidth-1:0] KIND_UNK = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NF    = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic [IdWidth-1:0]    id;
    logic [KindWidth-1:0]  kind;
    logic [ValueWidth-1:0] value;
  } krt_row_t;

  // Per-cell control: load a new row, take the right neighbor, take the head
  typedef struct packed {
    logic load;
    logic take_next;
    logic take_head;
  } krt_cell_ctl_t;

  // Keep text bytes up to the first zero byte, clear the rest
  function automatic logic [ValueWidth-1:0] krt_clip_text(
    input logic [ValueWidth-1:0] t
  );
    logic [ValueWidth-1:0] res;
    logic                  alive;
    res   = '0;
    alive = 1'b1;
    for (int b = 0; b < ValueWidth / 8; b++) begin
      if (t[8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        res[8*b +: 8] = t[8*b +: 8];
      end
    end
    return res;
  endfunction

  // Build the stored form of an added row
  function automatic krt_row_t krt_make_row(
    input logic [IdWidth-1:0]    id,
    input logic [KindWidth-1:0]  kind,
    input logic [IntWidth-1:0]   ival,
    input logic [ValueWidth-1:0] tval
  );
    krt_row_t r;
    r.id = id;
    case (kind)
      KIND_INT: begin
        r.kind  = KIND_INT;
        r.value = {{(ValueWidth - IntWidth){1'b0}}, ival};
      end
      KIND_TXT: begin
        r.kind  = KIND_TXT;
        r.value = krt_clip_text(tval);
      end
      default: begin
        r.kind  = KIND_UNK;
        r.value = '0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/keyed_row_table_compacting.sv
// Top level of the keyed row table: sequencer, output register and the
// chain of krt_cell rows. Depends on krt_pkg and krt_cell.
`default_nettype none

// Packed table of up to TABLE_DEPTH rows held in a chain of cells, row 0 at
// the head. An add returns the new id. A delete or a dump of a table holding
// n rows circulates the occupied part of the chain once, one row per cycle
// past the head while the output is not stalled; a delete drops the first
// matching row as it passes the head and the rest close up behind it. A dump
// gives one result per cycle while the consumer keeps ready high; a stalled
// output pauses the chain.
// Only one item is in progress at a time: in_ready_o is low until it ends.
module keyed_row_table_compacting
  import krt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             action_i,
  input  wire logic [KindWidth-1:0]   value_kind_i,
  input  wire logic signed [31:0]     int_value_i,
  input  wire logic [ValueWidth-1:0]  text_value_i,
  input  wire logic [IdWidth-1:0]     target_id_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  status_o,
  output logic [IdWidth-1:0]          row_id_o,
  output logic [KindWidth-1:0]        row_kind_o,
  output logic signed [31:0]          row_int_o,
  output logic [ValueWidth-1:0]       row_text_o,
  output logic                        last_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEL  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       steps_q, steps_d;
  logic [IdWidth-1:0]  next_id_q, next_id_d;
  logic [IdWidth-1:0]  target_q, target_d;
  logic                found_q, found_d;

  logic                out_valid_q;
  logic [1:0]          status_q, status_d;
  logic [IdWidth-1:0]  row_id_q, row_id_d;
  logic [KindWidth-1:0] row_kind_q, row_kind_d;
  logic [IntWidth-1:0] row_int_q, row_int_d;
  logic [ValueWidth-1:0] row_text_q, row_text_d;
  logic                last_q, last_d;
  logic                out_load;

  logic                slot_free;
  logic                accept;
  logic                add_en;
  logic                step_en;
  logic                drop;
  logic                rotate;
  krt_row_t            new_row;
  krt_row_t            head_row;
  krt_row_t            rows [TABLE_DEPTH];

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign head_row   = rows[0];
  assign step_en    = (state_q != ST_IDLE) && slot_free;
  assign drop       = (state_q == ST_DEL) && step_en && !found_q
                      && (head_row.id == target_q);
  assign rotate     = step_en && !drop;
  assign new_row    = krt_make_row(next_id_q, value_kind_i, int_value_i, text_value_i);

  // Sequence adds, deletes and dumps; build the next result item
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    steps_d    = steps_q;
    next_id_d  = next_id_q;
    target_d   = target_q;
    found_d    = found_q;
    add_en     = 1'b0;
    out_load   = 1'b0;
    status_d   = STAT_OK;
    row_id_d   = '0;
    row_kind_d = '0;
    row_int_d  = '0;
    row_text_d = '0;
    last_d     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_ADD: begin
              out_load = 1'b1;
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                add_en    = 1'b1;
                cnt_d     = cnt_q + 1'b1;
                row_id_d  = next_id_q;
                next_id_d = next_id_q + 1'b1;
              end
            end
            ACT_DEL: begin
              if (cnt_q == '0) begin
                out_load = 1'b1;
                status_d = STAT_NF;
                row_id_d = target_id_i;
              end else begin
                state_d  = ST_DEL;
                steps_d  = cnt_q;
                target_d = target_id_i;
                found_d  = 1'b0;
              end
            end
            ACT_DUMP: begin
              if (cnt_q == '0) begin
                out_load = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                state_d = ST_DUMP;
                steps_d = cnt_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DEL: begin
        if (step_en) begin
          steps_d = steps_q - 1'b1;
          if (drop) begin
            found_d = 1'b1;
            cnt_d   = cnt_q - 1'b1;
          end
          if (steps_q == CW'(1)) begin
            out_load = 1'b1;
            status_d = (found_q || drop) ? STAT_OK : STAT_NF;
            row_id_d = target_q;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        if (step_en) begin
          out_load   = 1'b1;
          row_id_d   = head_row.id;
          row_kind_d = head_row.kind;
          row_int_d  = (head_row.kind == KIND_INT) ? head_row.value[IntWidth-1:0] : '0;
          row_text_d = (head_row.kind == KIND_TXT) ? head_row.value : '0;
          last_d     = (steps_q == CW'(1));
          steps_d    = steps_q - 1'b1;
          if (steps_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      steps_q     <= '0;
      next_id_q   <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      steps_q   <= steps_d;
      next_id_q <= next_id_d;
      found_q   <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: target id and the output item
  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    if (out_load) begin
      status_q   <= status_d;
      row_id_q   <= row_id_d;
      row_kind_q <= row_kind_d;
      row_int_q  <= row_int_d;
      row_text_q <= row_text_d;
      last_q     <= last_d;
    end
  end

  // Cell chain: load an added row, rotate the occupied cells, or close up on a dropped head
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx   = CW'(i);
    localparam logic [CW-1:0] IdxP1 = CW'(i + 1);
    krt_cell_ctl_t ctl;
    krt_row_t      next_row;

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_row = rows[i];
    end else begin : g_mid
      assign next_row = rows[i+1];
    end

    always_comb begin
      ctl.load      = add_en && (cnt_q == Idx);
      ctl.take_next = (drop && (i != TABLE_DEPTH - 1))
                      || (rotate && (IdxP1 < cnt_q));
      ctl.take_head = rotate && (IdxP1 == cnt_q);
    end

    krt_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .new_row_i  (new_row),
      .next_row_i (next_row),
      .head_row_i (head_row),
      .row_o      (rows[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign row_id_o    = row_id_q;
  assign row_kind_o  = row_kind_q;
  assign row_int_o   = $signed(row_int_q);
  assign row_text_o  = row_text_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: hdl/krt_cell.sv
// One cell of the row chain: holds a single row and loads it from a new
// row, its right neighbor or the chain head. Depends on krt_pkg.
`default_nettype none

module krt_cell
  import krt_pkg::*;
(
  input  wire logic          clk_i,
  input  wire krt_cell_ctl_t ctl_i,
  input  wire krt_row_t      new_row_i,
  input  wire krt_row_t      next_row_i,
  input  wire krt_row_t      head_row_i,
  output krt_row_t           row_o
);

  krt_row_t row_q;
  krt_row_t row_d;

  // Select the source of this cycle's row
  always_comb begin
    row_d = row_q;
    if (ctl_i.load) begin
      row_d = new_row_i;
    end else if (ctl_i.take_next) begin
      row_d = next_row_i;
    end else if (ctl_i.take_head) begin
      row_d = head_row_i;
    end
  end

  // Hold the row; contents are meaningful only below the row count
  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign row_o = row_q;

endmodule

`default_nettype wire
